// ===== design/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, codes and constant tables shared by the request head parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam logic [15:0] MAX_URI_LEN_RST = 16'd2048;
  localparam logic [7:0]  MAX_HDR_CNT_RST = 8'd32;
  localparam logic [15:0] MAX_HDR_LEN_RST = 16'd8190;

  // register indexes of the configuration port
  localparam logic [1:0] REG_MAX_URI_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_HDR_CNT = 2'd1;
  localparam logic [1:0] REG_MAX_HDR_LEN = 2'd2;

  localparam int NUM_METHODS = 9;

  localparam logic [3:0] M_POST  = 4'd2;
  localparam logic [3:0] M_PUT   = 4'd3;
  localparam logic [3:0] M_PATCH = 4'd8;

  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_FAILED   = 2'd1;
  localparam logic [1:0] ST_NOBODY   = 2'd2;
  localparam logic [1:0] ST_BODY     = 2'd3;

  localparam logic [2:0] ROLE_NONE   = 3'd0;
  localparam logic [2:0] ROLE_METHOD = 3'd1;
  localparam logic [2:0] ROLE_URI    = 3'd2;
  localparam logic [2:0] ROLE_NAME   = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;

  localparam logic [1:0] VER_10   = 2'b01;
  localparam logic [1:0] VER_11   = 2'b10;
  localparam logic [1:0] VER_BOTH = 2'b11;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  localparam logic [7:0] METHOD_CHARS [NUM_METHODS][7] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T"},
    '{"O", "P", "T", "I", "O", "N", "S"},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00}
  };

  localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
  };

  localparam logic [7:0] VER_PREFIX [7] = '{"H", "T", "T", "P", "/", "1", "."};
  localparam logic [3:0] VER_DIGIT_POS = 4'd7;
  localparam logic [3:0] VER_END_POS   = 4'd8;
  localparam logic [3:0] TPOS_MAX      = 4'd15;

  typedef enum logic [3:0] {
    PH_METHOD      = 4'd0,
    PH_URI_FIRST   = 4'd1,
    PH_URI         = 4'd2,
    PH_VERSION     = 4'd3,
    PH_LINE        = 4'd4,
    PH_NAME        = 4'd5,
    PH_SKIP        = 4'd6,
    PH_VALUE       = 4'd7,
    PH_DONE_NOBODY = 4'd8,
    PH_DONE_BODY   = 4'd9,
    PH_FAILED      = 4'd10
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [8:0]  cand;
    logic [3:0]  tpos;
    logic [3:0]  meth;
    logic [1:0]  vcand;
    logic        last_dot;
    logic [7:0]  hdr_total;
    logic        pend_cr;
  } hrp_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] role;
    logic       hdone;
  } hrp_res_t;

  typedef struct packed {
    logic [15:0] max_uri_len;
    logic [7:0]  max_hdr_cnt;
    logic [15:0] max_hdr_len;
  } hrp_cfg_t;

  localparam hrp_state_t STATE_CLEAR = '{
    phase:     PH_METHOD,
    cand:      9'h1FF,
    tpos:      4'd0,
    meth:      4'd0,
    vcand:     VER_BOTH,
    last_dot:  1'b0,
    hdr_total: 8'd0,
    pend_cr:   1'b0
  };

endpackage

// ===== design/hrp_in_if.sv =====
// ----------------------------------------------------------------------------
// hrp_in_if
// Byte channel into the request head parser.
// ----------------------------------------------------------------------------
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink (input valid, data_byte, restart, output ready);
endinterface

// ===== design/hrp_out_if.sv =====
// ----------------------------------------------------------------------------
// hrp_out_if
// Per-byte result channel out of the request head parser.
// ----------------------------------------------------------------------------
interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  byte_role;
  logic        header_line_done;
  logic [3:0]  method_code;
  logic        version_code;
  logic [15:0] uri_length;
  logic [7:0]  header_count;

  modport source (output valid, status, byte_role, header_line_done, method_code,
                  version_code, uri_length, header_count, input ready);
  modport sink (input valid, status, byte_role, header_line_done, method_code,
                version_code, uri_length, header_count, output ready);
endinterface

// ===== design/hrp_step.sv =====
// ----------------------------------------------------------------------------
// hrp_step
// Next parse state and byte result for one request byte.
// ----------------------------------------------------------------------------
module hrp_step
  import hrp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  hrp_state_t             st_i,
  input  logic [LENGTH_BITS-1:0] uri_cnt_i,
  input  logic [LENGTH_BITS-1:0] line_len_i,
  input  logic [7:0]             data_byte,
  input  logic                   restart,
  input  hrp_cfg_t               cfg,
  output hrp_state_t             st_o,
  output logic [LENGTH_BITS-1:0] uri_cnt_o,
  output logic [LENGTH_BITS-1:0] line_len_o,
  output hrp_res_t               res_o
);

  hrp_state_t             cur;
  logic [LENGTH_BITS-1:0] uc;
  logic [LENGTH_BITS-1:0] ll;
  logic [LENGTH_BITS-1:0] uc_b;
  logic [LENGTH_BITS-1:0] ll_b;
  logic                   uri_over;
  logic                   line_over;
  logic                   active;
  logic                   has_body;

  assign cur  = restart ? STATE_CLEAR : st_i;
  assign uc   = restart ? '0 : uri_cnt_i;
  assign ll   = restart ? '0 : line_len_i;
  assign uc_b = (uc == '1) ? uc : uc + 1'b1;
  assign ll_b = (ll == '1) ? ll : ll + 1'b1;

  assign uri_over  = 32'(uc_b) > 32'(cfg.max_uri_len);
  assign line_over = 32'(ll_b) > 32'(cfg.max_hdr_len);
  assign active    = cur.phase < PH_DONE_NOBODY;
  assign has_body  = (cur.meth == M_POST) || (cur.meth == M_PUT) || (cur.meth == M_PATCH);

  // next state
  always_comb begin
    logic [3:0] found;
    logic       hit;
    st_o       = cur;
    uri_cnt_o  = uc;
    line_len_o = ll;
    found      = '0;
    hit        = 1'b0;
    if (active && cur.pend_cr) begin
      st_o.pend_cr = 1'b0;
      if (data_byte != CH_LF) begin
        st_o.phase = PH_FAILED;
      end else if (cur.phase == PH_VERSION) begin
        st_o.phase = PH_LINE;
      end else if (cur.phase == PH_LINE) begin
        st_o.phase = has_body ? PH_DONE_BODY : PH_DONE_NOBODY;
      end else begin
        st_o.hdr_total = cur.hdr_total + 8'd1;
        line_len_o     = '0;
        st_o.phase     = PH_LINE;
      end
    end else if (active && data_byte == CH_LF) begin
      st_o.phase = PH_FAILED;
    end else begin
      unique case (cur.phase)
        PH_METHOD: begin
          if (data_byte == CH_SP) begin
            for (int i = 0; i < NUM_METHODS; i++) begin
              if (cur.cand[i] && METHOD_LEN[i] == cur.tpos) begin
                found = 4'(i);
                hit   = 1'b1;
              end
            end
            if (hit) begin
              st_o.meth  = found;
              st_o.phase = PH_URI_FIRST;
            end else begin
              st_o.phase = PH_FAILED;
            end
          end else if (data_byte == CH_CR) begin
            st_o.phase = PH_FAILED;
          end else begin
            for (int i = 0; i < NUM_METHODS; i++) begin
              if (cur.tpos >= METHOD_LEN[i] ||
                  METHOD_CHARS[i][cur.tpos[2:0]] != data_byte) begin
                st_o.cand[i] = 1'b0;
              end
            end
            if (cur.tpos < TPOS_MAX) begin
              st_o.tpos = cur.tpos + 4'd1;
            end
          end
        end
        PH_URI_FIRST: begin
          if (data_byte != CH_SLASH) begin
            st_o.phase = PH_FAILED;
          end else begin
            uri_cnt_o = uc_b;
            if (uri_over) begin
              st_o.phase = PH_FAILED;
            end else begin
              st_o.last_dot = 1'b0;
              st_o.phase    = PH_URI;
            end
          end
        end
        PH_URI: begin
          if (data_byte == CH_SP) begin
            st_o.phase = PH_VERSION;
            st_o.tpos  = '0;
          end else if (data_byte == CH_CR || (data_byte == CH_DOT && cur.last_dot)) begin
            st_o.phase = PH_FAILED;
          end else begin
            uri_cnt_o = uc_b;
            if (uri_over) begin
              st_o.phase = PH_FAILED;
            end else begin
              st_o.last_dot = (data_byte == CH_DOT);
            end
          end
        end
        PH_VERSION: begin
          if (cur.tpos < VER_DIGIT_POS) begin
            if (VER_PREFIX[cur.tpos[2:0]] != data_byte) begin
              st_o.phase = PH_FAILED;
            end else begin
              st_o.tpos = cur.tpos + 4'd1;
            end
          end else if (cur.tpos == VER_DIGIT_POS) begin
            if (data_byte == CH_ZERO) begin
              st_o.vcand = VER_10;
              st_o.tpos  = VER_END_POS;
            end else if (data_byte == CH_ONE) begin
              st_o.vcand = VER_11;
              st_o.tpos  = VER_END_POS;
            end else begin
              st_o.phase = PH_FAILED;
            end
          end else if (data_byte != CH_CR) begin
            st_o.phase = PH_FAILED;
          end else if (cur.vcand == VER_10 && cur.meth > M_POST) begin
            st_o.phase = PH_FAILED;
          end else begin
            st_o.pend_cr = 1'b1;
          end
        end
        PH_LINE: begin
          if (data_byte == CH_CR) begin
            st_o.pend_cr = 1'b1;
          end else if (cur.hdr_total >= cfg.max_hdr_cnt) begin
            st_o.phase = PH_FAILED;
          end else if (data_byte == CH_COLON) begin
            line_len_o = '0;
            st_o.phase = PH_SKIP;
          end else begin
            // line length restarts at zero, so the bumped value is one
            line_len_o = LENGTH_BITS'(1);
            st_o.phase = (32'd1 > 32'(cfg.max_hdr_len)) ? PH_FAILED : PH_NAME;
          end
        end
        PH_NAME: begin
          if (data_byte == CH_COLON) begin
            st_o.phase = PH_SKIP;
          end else if (data_byte == CH_CR) begin
            st_o.phase = PH_FAILED;
          end else begin
            line_len_o = ll_b;
            if (line_over) begin
              st_o.phase = PH_FAILED;
            end
          end
        end
        PH_SKIP, PH_VALUE: begin
          if (data_byte == CH_CR) begin
            st_o.pend_cr = 1'b1;
          end else if (!(cur.phase == PH_SKIP &&
                         (data_byte == CH_SP || data_byte == CH_TAB))) begin
            line_len_o = ll_b;
            st_o.phase = line_over ? PH_FAILED : PH_VALUE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // byte result
  always_comb begin
    res_o.role  = ROLE_NONE;
    res_o.hdone = 1'b0;
    unique case (st_o.phase)
      PH_FAILED:      res_o.status = ST_FAILED;
      PH_DONE_NOBODY: res_o.status = ST_NOBODY;
      PH_DONE_BODY:   res_o.status = ST_BODY;
      default:        res_o.status = ST_PROGRESS;
    endcase
    case (cur.phase)
      PH_METHOD: begin
        if (st_o.phase == PH_METHOD) res_o.role = ROLE_METHOD;
      end
      PH_URI_FIRST, PH_URI: begin
        if (st_o.phase == PH_URI) res_o.role = ROLE_URI;
      end
      PH_LINE, PH_NAME: begin
        if (st_o.phase == PH_NAME) res_o.role = ROLE_NAME;
      end
      PH_SKIP, PH_VALUE: begin
        if (st_o.phase == PH_VALUE && !st_o.pend_cr) res_o.role = ROLE_VALUE;
        if (cur.pend_cr && st_o.phase == PH_LINE) res_o.hdone = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/http_request_head_parser_unit.sv =====
// ----------------------------------------------------------------------------
// http_request_head_parser_unit
// HTTP/1.0 and HTTP/1.1 request line and header parser, one byte per transfer.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result, in order. A byte passes an
// input register, the combinational parse logic and a result register, so the
// unit takes a byte every cycle while the result side keeps up; the parse
// state and counters update with each result register load, which sets that rate.
// Result back-pressure stalls the input only when both registers are full.
// Limits are to be written over the APB port only while idle; the unit does not enforce this.
module http_request_head_parser_unit
  import hrp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hrp_in_if.sink      in_stream,
  hrp_out_if.source   out_stream,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hrp_cfg_t               cfg_r;
  logic                   cfg_wr;
  logic [1:0]             reg_idx;

  logic                   ibuf_vld_r;
  logic [7:0]             ibuf_byte_r;
  logic                   ibuf_restart_r;
  logic                   obuf_vld_r;
  logic                   advance;

  hrp_state_t             state_r;
  hrp_state_t             state_nxt;
  logic [LENGTH_BITS-1:0] uri_cnt_r;
  logic [LENGTH_BITS-1:0] uri_cnt_nxt;
  logic [LENGTH_BITS-1:0] line_len_r;
  logic [LENGTH_BITS-1:0] line_len_nxt;
  hrp_res_t               res;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_uri_len <= MAX_URI_LEN_RST;
      cfg_r.max_hdr_cnt <= MAX_HDR_CNT_RST;
      cfg_r.max_hdr_len <= MAX_HDR_LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_URI_LEN: cfg_r.max_uri_len <= pwdata[15:0];
        REG_MAX_HDR_CNT: cfg_r.max_hdr_cnt <= pwdata[7:0];
        REG_MAX_HDR_LEN: cfg_r.max_hdr_len <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_URI_LEN: prdata = {16'd0, cfg_r.max_uri_len};
      REG_MAX_HDR_CNT: prdata = {24'd0, cfg_r.max_hdr_cnt};
      REG_MAX_HDR_LEN: prdata = {16'd0, cfg_r.max_hdr_len};
      default:         prdata = 32'd0;
    endcase
  end

  // datapath handshake
  assign advance         = ibuf_vld_r && (!obuf_vld_r || out_stream.ready);
  assign in_stream.ready = !ibuf_vld_r || advance;
  assign out_stream.valid = obuf_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ibuf_vld_r <= 1'b0;
      obuf_vld_r <= 1'b0;
    end else begin
      if (in_stream.ready) ibuf_vld_r <= in_stream.valid;
      if (advance) begin
        obuf_vld_r <= 1'b1;
      end else if (out_stream.ready) begin
        obuf_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      ibuf_byte_r    <= in_stream.data_byte;
      ibuf_restart_r <= in_stream.restart;
    end
  end

  hrp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .st_i       (state_r),
    .uri_cnt_i  (uri_cnt_r),
    .line_len_i (line_len_r),
    .data_byte  (ibuf_byte_r),
    .restart    (ibuf_restart_r),
    .cfg        (cfg_r),
    .st_o       (state_nxt),
    .uri_cnt_o  (uri_cnt_nxt),
    .line_len_o (line_len_nxt),
    .res_o      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= STATE_CLEAR;
      uri_cnt_r  <= '0;
      line_len_r <= '0;
    end else if (advance) begin
      state_r    <= state_nxt;
      uri_cnt_r  <= uri_cnt_nxt;
      line_len_r <= line_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stream.status           <= res.status;
      out_stream.byte_role        <= res.role;
      out_stream.header_line_done <= res.hdone;
      out_stream.method_code      <= state_nxt.meth;
      out_stream.version_code     <= (state_nxt.vcand == VER_11);
      out_stream.uri_length       <= 16'(uri_cnt_nxt);
      out_stream.header_count     <= state_nxt.hdr_total;
    end
  end

  // checks
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    obuf_vld_r && out_stream.status == ST_FAILED
      |-> out_stream.byte_role == ROLE_NONE && !out_stream.header_line_done)
    else $error("failed result carries a role or line done");

  a_hdone_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.hdone
      |=> out_stream.header_count == $past(state_r.hdr_total) + 8'd1)
    else $error("header line done without count step");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.phase == PH_FAILED && !ibuf_restart_r
      |=> state_r.phase == PH_FAILED)
    else $error("failed parse left without restart");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ibuf_vld_r && obuf_vld_r && !out_stream.ready |-> !in_stream.ready && !advance)
    else $error("input taken while both buffers full");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTTP request head parser unit. Streams of
// request bytes are built from well-formed requests with random content,
// then damaged, cut short or padded now and then. Every accepted byte goes
// through a local model of the parser. Each result transfer is compared field
// by field with the oldest predicted result. The limit registers are
// rewritten between phases while the unit is idle. Both channel sides
// idle at random, and once the result side holds off long enough to back
// up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import hrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int LONG_HOLD_AFTER = 700;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } stream_byte_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  role;
    logic        line_done;
    logic [3:0]  verb;
    logic        version;
    logic [15:0] uri_len;
    logic [7:0]  hdr_count;
  } head_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hrp_in_if  in_if ();
  hrp_out_if out_if ();

  http_request_head_parser_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_if),
    .out_stream(out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  string verb_names [9] = '{"GET", "HEAD", "POST", "PUT", "DELETE", "CONNECT",
                            "OPTIONS", "TRACE", "PATCH"};
  string ver_lead = "HTTP/1.";
  string uri_chars = "abcxyz0189/.-_?=&%~";
  string name_chars = "ABCHostacceptz-09";

  // parser model state and limits
  phase_t      ph;
  logic [8:0]  verb_cand;
  logic [3:0]  tok_pos;
  logic [3:0]  verb_code;
  logic [1:0]  ver_cand;
  logic [15:0] uri_cnt;
  logic        prev_dot;
  logic [7:0]  hdr_cnt;
  logic [15:0] line_cnt;
  logic        cr_seen;
  logic [15:0] lim_uri;
  logic [7:0]  lim_hdr_cnt;
  logic [15:0] lim_hdr_len;

  stream_byte_t bytes_to_send [$];
  stream_byte_t next_byte;
  logic [7:0]   request_bytes [$];
  head_result_t head_results_due [$];
  head_result_t due_now;
  logic         next_restart;

  int  bytes_made;
  int  bytes_taken;
  int  rx_count;
  int  fail_count;
  int  idle_cycles;
  int  send_gap;
  int  recv_wait;
  int  long_hold_cnt;
  bit  long_hold_used;
  bit  send_quiet;
  bit  recv_quiet;
  bit  in_taken;
  bit  out_taken;

  always #10 clk = ~clk;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic clear_parse_state();
    ph = PH_METHOD;
    verb_cand = 9'h1FF;
    tok_pos = '0;
    verb_code = '0;
    ver_cand = VER_BOTH;
    uri_cnt = '0;
    prev_dot = 1'b0;
    hdr_cnt = '0;
    line_cnt = '0;
    cr_seen = 1'b0;
  endtask

  task automatic advance_parser(input logic [7:0] b, input logic fresh,
                                output head_result_t r);
    int found;
    r = '0;
    if (fresh) clear_parse_state();
    if (ph < PH_DONE_NOBODY && cr_seen) begin
      cr_seen = 1'b0;
      if (b != CH_LF) begin
        ph = PH_FAILED;
      end else if (ph == PH_VERSION) begin
        ph = PH_LINE;
      end else if (ph == PH_LINE) begin
        if (verb_code == M_POST || verb_code == M_PUT || verb_code == M_PATCH) ph = PH_DONE_BODY;
        else ph = PH_DONE_NOBODY;
      end else begin
        hdr_cnt = hdr_cnt + 8'd1;
        line_cnt = '0;
        r.line_done = 1'b1;
        ph = PH_LINE;
      end
    end else if (ph < PH_DONE_NOBODY && b == CH_LF) begin
      ph = PH_FAILED;
    end else begin
      case (ph)
        PH_METHOD: begin
          if (b == CH_SP) begin
            found = -1;
            for (int i = 0; i < 9; i++) begin
              if (verb_cand[i] && 4'(verb_names[i].len()) == tok_pos) found = i;
            end
            if (found >= 0) begin
              verb_code = 4'(found);
              ph = PH_URI_FIRST;
            end else begin
              ph = PH_FAILED;
            end
          end else if (b == CH_CR) begin
            ph = PH_FAILED;
          end else begin
            for (int i = 0; i < 9; i++) begin
              if (tok_pos >= 4'(verb_names[i].len()) || verb_names[i][tok_pos] != b) begin
                verb_cand[i] = 1'b0;
              end
            end
            if (tok_pos != TPOS_MAX) tok_pos = tok_pos + 4'd1;
            r.role = ROLE_METHOD;
          end
        end
        PH_URI_FIRST: begin
          if (b != CH_SLASH) begin
            ph = PH_FAILED;
          end else begin
            uri_cnt = sat_inc(uri_cnt);
            if (uri_cnt > lim_uri) begin
              ph = PH_FAILED;
            end else begin
              prev_dot = 1'b0;
              r.role = ROLE_URI;
              ph = PH_URI;
            end
          end
        end
        PH_URI: begin
          if (b == CH_SP) begin
            ph = PH_VERSION;
            tok_pos = '0;
          end else if (b == CH_CR || (b == CH_DOT && prev_dot)) begin
            ph = PH_FAILED;
          end else begin
            uri_cnt = sat_inc(uri_cnt);
            if (uri_cnt > lim_uri) begin
              ph = PH_FAILED;
            end else begin
              prev_dot = (b == CH_DOT);
              r.role = ROLE_URI;
            end
          end
        end
        PH_VERSION: begin
          if (tok_pos < VER_DIGIT_POS) begin
            if (ver_lead[tok_pos] != b) ph = PH_FAILED;
            else tok_pos = tok_pos + 4'd1;
          end else if (tok_pos == VER_DIGIT_POS) begin
            if (b == CH_ZERO) begin
              ver_cand = VER_10;
              tok_pos = VER_END_POS;
            end else if (b == CH_ONE) begin
              ver_cand = VER_11;
              tok_pos = VER_END_POS;
            end else begin
              ph = PH_FAILED;
            end
          end else if (b != CH_CR) begin
            ph = PH_FAILED;
          end else if (ver_cand == VER_10 && verb_code > M_POST) begin
            ph = PH_FAILED;
          end else begin
            cr_seen = 1'b1;
          end
        end
        PH_LINE: begin
          if (b == CH_CR) begin
            cr_seen = 1'b1;
          end else if (hdr_cnt >= lim_hdr_cnt) begin
            ph = PH_FAILED;
          end else begin
            line_cnt = '0;
            if (b == CH_COLON) begin
              ph = PH_SKIP;
            end else begin
              line_cnt = sat_inc(line_cnt);
              if (line_cnt > lim_hdr_len) begin
                ph = PH_FAILED;
              end else begin
                r.role = ROLE_NAME;
                ph = PH_NAME;
              end
            end
          end
        end
        PH_NAME: begin
          if (b == CH_COLON) begin
            ph = PH_SKIP;
          end else if (b == CH_CR) begin
            ph = PH_FAILED;
          end else begin
            line_cnt = sat_inc(line_cnt);
            if (line_cnt > lim_hdr_len) ph = PH_FAILED;
            else r.role = ROLE_NAME;
          end
        end
        PH_SKIP, PH_VALUE: begin
          if (b == CH_CR) begin
            cr_seen = 1'b1;
          end else if (!(ph == PH_SKIP && (b == CH_SP || b == CH_TAB))) begin
            line_cnt = sat_inc(line_cnt);
            if (line_cnt > lim_hdr_len) begin
              ph = PH_FAILED;
            end else begin
              r.role = ROLE_VALUE;
              ph = PH_VALUE;
            end
          end
        end
        default: ;
      endcase
    end
    case (ph)
      PH_FAILED: begin
        r.status = ST_FAILED;
        r.role = ROLE_NONE;
        r.line_done = 1'b0;
      end
      PH_DONE_NOBODY: r.status = ST_NOBODY;
      PH_DONE_BODY:   r.status = ST_BODY;
      default:        r.status = ST_PROGRESS;
    endcase
    r.verb = verb_code;
    r.version = (ver_cand == VER_11);
    r.uri_len = uri_cnt;
    r.hdr_count = hdr_cnt;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("[%0t] result %0d %s: got %0h, want %0h", $time, rx_count, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic push_char(input logic [7:0] b);
    bytes_to_send.push_back('{data: b, restart: next_restart});
    next_restart = 1'b0;
    bytes_made++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endtask

  // build one request, mostly well formed, then damage it now and then
  task automatic queue_request();
    int len;
    int pos;
    int pick;
    int n_hdr;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      len = $urandom_range(1, 6);
      repeat (len) request_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        add_text(verb_names[$urandom_range(0, 8)]);
      end else if (pick < 92) begin
        len = $urandom_range(1, 8);
        repeat (len) request_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
      end
      request_bytes.push_back(CH_SP);
      request_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_SLASH);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) request_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
        else request_bytes.push_back(uri_chars[$urandom_range(0, uri_chars.len() - 1)]);
      end
      if ($urandom_range(0, 9) == 0) begin
        request_bytes.push_back(CH_DOT);
        request_bytes.push_back(CH_DOT);
      end
      request_bytes.push_back(CH_SP);
      add_text(ver_lead);
      request_bytes.push_back(($urandom_range(0, 2) == 0) ? CH_ZERO : CH_ONE);
      if ($urandom_range(0, 19) == 0) begin
        request_bytes[request_bytes.size() - 1 - $urandom_range(0, 7)] = 8'($urandom_range(0, 255));
      end
      request_bytes.push_back(CH_CR);
      request_bytes.push_back(CH_LF);
      n_hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      repeat (n_hdr) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (len) request_bytes.push_back(name_chars[$urandom_range(0, name_chars.len() - 1)]);
        request_bytes.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) request_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        repeat ($urandom_range(0, 10)) request_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        request_bytes.push_back(CH_CR);
        request_bytes.push_back(CH_LF);
      end
      request_bytes.push_back(CH_CR);
      request_bytes.push_back(CH_LF);
      if ($urandom_range(0, 99) < 15) begin
        pos = $urandom_range(0, request_bytes.size() - 1);
        case ($urandom_range(0, 3))
          0: request_bytes[pos] = 8'($urandom_range(0, 255));
          1: request_bytes[pos] = CH_CR;
          2: request_bytes[pos] = CH_LF;
          default: request_bytes.delete(pos);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        pos = $urandom_range(0, request_bytes.size() - 1);
        request_bytes = request_bytes[0:pos];
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) request_bytes.push_back(8'($urandom_range(0, 255)));
    end
    next_restart = 1'b1;
    foreach (request_bytes[k]) push_char(request_bytes[k]);
    request_bytes.delete();
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_made || head_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_URI_LEN: lim_uri = val[15:0];
      REG_MAX_HDR_CNT: lim_hdr_cnt = val[7:0];
      REG_MAX_HDR_LEN: lim_hdr_len = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int uri_max, input int cnt_max, input int len_max);
    write_limit(REG_MAX_URI_LEN, 32'(uri_max));
    write_limit(REG_MAX_HDR_CNT, 32'(cnt_max));
    write_limit(REG_MAX_HDR_LEN, 32'(len_max));
  endtask

  task automatic run_phase(input int n_bytes);
    int start;
    start = bytes_made;
    while (bytes_made - start < n_bytes) queue_request();
    wait_idle();
  endtask

  // sample both channels, predict and compare
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
      out_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_if.valid && in_if.ready;
      out_taken = out_if.valid && out_if.ready;
      if (in_taken) begin
        advance_parser(in_if.data_byte, in_if.restart, due_now);
        head_results_due.push_back(due_now);
        bytes_taken++;
      end
      if (out_taken) begin
        if (head_results_due.size() == 0) begin
          report_mismatch("unexpected transfer", 16'(out_if.status), '0);
        end else begin
          due_now = head_results_due.pop_front();
          check_field("status", 16'(out_if.status), 16'(due_now.status));
          check_field("byte_role", 16'(out_if.byte_role), 16'(due_now.role));
          check_field("header_line_done", 16'(out_if.header_line_done),
                      16'(due_now.line_done));
          check_field("method_code", 16'(out_if.method_code), 16'(due_now.verb));
          check_field("version_code", 16'(out_if.version_code), 16'(due_now.version));
          check_field("uri_length", out_if.uri_length, due_now.uri_len);
          check_field("header_count", 16'(out_if.header_count), 16'(due_now.hdr_count));
        end
        rx_count++;
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // byte driver: hold until transfer, then gap, then next byte
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      in_if.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_if.valid <= 1'b0;
    end else if (bytes_to_send.size() != 0) begin
      next_byte = bytes_to_send.pop_front();
      in_if.data_byte <= next_byte.data;
      in_if.restart <= next_byte.restart;
      in_if.valid <= 1'b1;
      send_gap = (send_quiet || long_hold_cnt != 0) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result receiver: random stall per transfer, one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (!long_hold_used && rx_count >= LONG_HOLD_AFTER) begin
        long_hold_cnt = LONG_HOLD_CYCLES;
        long_hold_used = 1'b1;
      end
      if (long_hold_cnt != 0) begin
        long_hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        if (out_taken) begin
          recv_wait = recv_quiet ? 0 : $urandom_range(0, 19);
          if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
        end
        if (recv_wait != 0) begin
          recv_wait--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.restart = 1'b0;
    out_if.ready = 1'b0;
    lim_uri = MAX_URI_LEN_RST;
    lim_hdr_cnt = MAX_HDR_CNT_RST;
    lim_hdr_len = MAX_HDR_LEN_RST;
    clear_parse_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unknown method with extreme bytes, empty method, short request with an empty header name
    next_restart = 1'b1;
    push_char(8'hFF);
    push_char(8'h00);
    push_char(CH_SP);
    next_restart = 1'b1;
    push_char(CH_SP);
    next_restart = 1'b1;
    foreach (request_bytes[k]) push_char(request_bytes[k]);
    add_text("GET / HTTP/1.1");
    request_bytes.push_back(CH_CR);
    request_bytes.push_back(CH_LF);
    request_bytes.push_back(CH_COLON);
    request_bytes.push_back(CH_TAB);
    request_bytes.push_back(CH_CR);
    request_bytes.push_back(CH_LF);
    request_bytes.push_back(CH_CR);
    request_bytes.push_back(CH_LF);
    foreach (request_bytes[k]) push_char(request_bytes[k]);
    request_bytes.delete();

    run_phase(180);
    set_limits(1, 0, 1);
    run_phase(200);
    set_limits(16'hFFFF, 8'hFF, 16'hFFFF);
    run_phase(200);
    set_limits($urandom_range(1, 12), $urandom_range(0, 4), $urandom_range(1, 16));
    run_phase(220);
    set_limits($urandom_range(1, 65535), $urandom_range(0, 255), $urandom_range(1, 65535));
    run_phase(200);
    set_limits($urandom_range(2, 20), $urandom_range(1, 6), $urandom_range(4, 24));
    run_phase(220);

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
